// File: hw/rtl/sks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sks_pkg;

	localparam logic [3:0] OP_INSERT    = 4'd0;
	localparam logic [3:0] OP_REMOVE    = 4'd1;
	localparam logic [3:0] OP_EXISTS    = 4'd2;
	localparam logic [3:0] OP_MIN       = 4'd3;
	localparam logic [3:0] OP_MAX       = 4'd4;
	localparam logic [3:0] OP_TAKE_MIN  = 4'd5;
	localparam logic [3:0] OP_TAKE_MAX  = 4'd6;
	localparam logic [3:0] OP_PRED      = 4'd7;
	localparam logic [3:0] OP_TAKE_PRED = 4'd8;
	localparam logic [3:0] OP_SUCC      = 4'd9;
	localparam logic [3:0] OP_TAKE_SUCC = 4'd10;
	localparam logic [3:0] OP_RANK      = 4'd11;
	localparam logic [3:0] OP_CLEAR     = 4'd12;

	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_MISS  = 3'd1;
	localparam logic [2:0] STAT_EMPTY = 3'd2;
	localparam logic [2:0] STAT_FULL  = 3'd3;
	localparam logic [2:0] STAT_NONE  = 3'd4;
	localparam logic [2:0] STAT_RANGE = 3'd5;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [31:0] key;
		logic [5:0]  rank_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] value;
		logic [6:0]  count;
	} rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/sorted_key_set_table.sv
// Sorted key set: keeps up to CAPACITY distinct keys in ascending order in a
// circular RAM (rank r sits at slot (first + r) mod CAPACITY).
// Request channel req_valid/req_ready/req carries one item: type, key, rank.
// Response channel rsp_valid/rsp_ready/rsp returns one item per request:
// status, value and the key count after the request.
// One request is worked at a time; req_ready is high only while idle.
// Work per item, set by the single RAM port and the shared slot adder:
//   min/max/rank read/clear and empty/range misses: no search, no shifting
//   searches: one RAM read per binary-search step, ceil(log2(count+1)) steps
//   insert: plus a read and a write per key shifted up (keys ranked above the new one)
//   remove/take: plus a read and a write per key shifted down (none at rank 0)
// The response sits in an output register; the next request is taken while
// it waits. If the receiver stalls, a finished item holds in the sequencer
// until the output register frees up.
// Reset empties the table and clears the head slot; RAM contents are left
// as is and are never used before being written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_set_table #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire sks_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output sks_pkg::rsp_t      rsp
);

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > 6) ? CW : 6;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_START  = 4'd1;
	localparam logic [3:0] ST_SRCH   = 4'd2;
	localparam logic [3:0] ST_SCMP   = 4'd3;
	localparam logic [3:0] ST_POST   = 4'd4;
	localparam logic [3:0] ST_EXAM   = 4'd5;
	localparam logic [3:0] ST_ISH_RD = 4'd6;
	localparam logic [3:0] ST_ISH_WR = 4'd7;
	localparam logic [3:0] ST_DRD    = 4'd8;
	localparam logic [3:0] ST_DWR    = 4'd9;
	localparam logic [3:0] ST_FIN    = 4'd10;

	logic [3:0]           state_q;
	logic [3:0]           type_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [5:0]           idx_q;
	logic [2:0]           status_q;
	logic [31:0]          value_q;
	logic [SW-1:0]        first_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        lo_q;
	logic [CW-1:0]        hi_q;
	logic [CW-1:0]        mid_q;
	logic [CW-1:0]        pos_q;
	logic [CW-1:0]        cur_q;
	logic                 rsp_valid_q;
	sks_pkg::rsp_t        rsp_q;

	logic [KEY_WIDTH-1:0] mem [CAPACITY];
	logic [KEY_WIDTH-1:0] rdata_q;

	logic [CW-1:0]        rank;
	logic [SW+1:0]        slot_sum;
	logic [SW-1:0]        slot;
	logic                 we;
	logic [KEY_WIDTH-1:0] wdata;
	logic [CW:0]          mid_sum;
	logic [CW-1:0]        mid;
	logic [CW-1:0]        start_pos;
	logic [CW-1:0]        post_pos;
	logic                 strict;
	logic                 is_pred;
	logic                 is_take;
	logic                 full;
	logic                 empty;
	logic                 key_lt;
	logic                 key_eq;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign full    = (count_q == CW'(CAPACITY));
	assign empty   = (count_q == '0);
	assign strict  = (type_q == sks_pkg::OP_SUCC) || (type_q == sks_pkg::OP_TAKE_SUCC);
	assign is_pred = (type_q == sks_pkg::OP_PRED) || (type_q == sks_pkg::OP_TAKE_PRED);
	assign is_take = (type_q == sks_pkg::OP_TAKE_MIN) || (type_q == sks_pkg::OP_TAKE_MAX)
		|| (type_q == sks_pkg::OP_TAKE_PRED) || (type_q == sks_pkg::OP_TAKE_SUCC);
	assign key_lt  = (rdata_q < key_q);
	assign key_eq  = (rdata_q == key_q);

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[CW:1];
	assign post_pos = is_pred ? (lo_q - CW'(1)) : lo_q;

	always_comb begin
		case (type_q)
			sks_pkg::OP_MAX, sks_pkg::OP_TAKE_MAX: begin
				start_pos = count_q - CW'(1);
			end
			sks_pkg::OP_RANK: begin
				start_pos = CW'(idx_q);
			end
			default: begin
				start_pos = '0;
			end
		endcase
	end

	// shared slot unit: rank -> physical slot, sum stays below 2*CAPACITY for ranks up to CAPACITY
	assign slot_sum = (SW + 2)'(first_q) + (SW + 2)'(rank);
	assign slot = (slot_sum >= (SW + 2)'(CAPACITY)) ?
		SW'(slot_sum - (SW + 2)'(CAPACITY)) : SW'(slot_sum);

	always_comb begin
		rank  = '0;
		we    = 1'b0;
		wdata = rdata_q;
		case (state_q)
			ST_START: begin
				rank = start_pos;
			end
			ST_SRCH: begin
				rank = mid;
			end
			ST_POST: begin
				rank = post_pos;
			end
			ST_EXAM: begin
				rank = CW'(1);
			end
			ST_ISH_RD: begin
				if (cur_q > pos_q) begin
					rank = cur_q - CW'(1);
				end else begin
					rank  = pos_q;
					we    = 1'b1;
					wdata = key_q;
				end
			end
			ST_ISH_WR: begin
				rank = cur_q;
				we   = 1'b1;
			end
			ST_DRD: begin
				rank = cur_q + CW'(1);
			end
			ST_DWR: begin
				rank = cur_q;
				we   = 1'b1;
			end
			default: begin
				rank = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[slot] <= wdata;
		end
		rdata_q <= mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a finishing item reloads the output register itself
			if (rsp_valid_q && rsp_ready && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						type_q   <= req.req_type;
						key_q    <= KEY_WIDTH'(req.key);
						idx_q    <= req.rank_index;
						status_q <= sks_pkg::STAT_OK;
						value_q  <= '0;
						state_q  <= ST_START;
					end
				end
				ST_START: begin
					lo_q  <= '0;
					hi_q  <= count_q;
					pos_q <= start_pos;
					case (type_q)
						sks_pkg::OP_INSERT, sks_pkg::OP_REMOVE, sks_pkg::OP_EXISTS: begin
							state_q <= ST_SRCH;
						end
						sks_pkg::OP_MIN, sks_pkg::OP_MAX,
						sks_pkg::OP_TAKE_MIN, sks_pkg::OP_TAKE_MAX: begin
							if (empty) begin
								status_q <= sks_pkg::STAT_EMPTY;
								state_q  <= ST_FIN;
							end else begin
								state_q <= ST_EXAM;
							end
						end
						sks_pkg::OP_PRED, sks_pkg::OP_TAKE_PRED,
						sks_pkg::OP_SUCC, sks_pkg::OP_TAKE_SUCC: begin
							if (empty) begin
								status_q <= sks_pkg::STAT_EMPTY;
								state_q  <= ST_FIN;
							end else begin
								state_q <= ST_SRCH;
							end
						end
						sks_pkg::OP_RANK: begin
							if (IW'(idx_q) >= IW'(count_q)) begin
								status_q <= sks_pkg::STAT_RANGE;
								state_q  <= ST_FIN;
							end else begin
								state_q <= ST_EXAM;
							end
						end
						sks_pkg::OP_CLEAR: begin
							first_q <= '0;
							count_q <= '0;
							state_q <= ST_FIN;
						end
						default: begin
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_SRCH: begin
					mid_q <= mid;
					if (lo_q < hi_q) begin
						state_q <= ST_SCMP;
					end else begin
						state_q <= ST_POST;
					end
				end
				ST_SCMP: begin
					if (key_lt || (strict && key_eq)) begin
						lo_q <= mid_q + CW'(1);
					end else begin
						hi_q <= mid_q;
					end
					state_q <= ST_SRCH;
				end
				ST_POST: begin
					pos_q <= post_pos;
					case (type_q)
						sks_pkg::OP_INSERT: begin
							if (lo_q < count_q) begin
								state_q <= ST_EXAM;
							end else if (full) begin
								status_q <= sks_pkg::STAT_FULL;
								state_q  <= ST_FIN;
							end else begin
								cur_q   <= count_q;
								state_q <= ST_ISH_RD;
							end
						end
						sks_pkg::OP_PRED, sks_pkg::OP_TAKE_PRED: begin
							if (lo_q == '0) begin
								status_q <= sks_pkg::STAT_NONE;
								state_q  <= ST_FIN;
							end else begin
								state_q <= ST_EXAM;
							end
						end
						default: begin
							if (lo_q < count_q) begin
								state_q <= ST_EXAM;
							end else begin
								status_q <= strict ? sks_pkg::STAT_NONE : sks_pkg::STAT_MISS;
								state_q  <= ST_FIN;
							end
						end
					endcase
				end
				ST_EXAM: begin
					case (type_q)
						sks_pkg::OP_INSERT: begin
							if (key_eq) begin
								status_q <= sks_pkg::STAT_MISS;
								state_q  <= ST_FIN;
							end else if (full) begin
								status_q <= sks_pkg::STAT_FULL;
								state_q  <= ST_FIN;
							end else begin
								cur_q   <= count_q;
								state_q <= ST_ISH_RD;
							end
						end
						sks_pkg::OP_REMOVE, sks_pkg::OP_EXISTS: begin
							if (!key_eq) begin
								status_q <= sks_pkg::STAT_MISS;
								state_q  <= ST_FIN;
							end else if (type_q == sks_pkg::OP_EXISTS) begin
								state_q <= ST_FIN;
							end else if (pos_q == '0) begin
								first_q <= slot;
								count_q <= count_q - CW'(1);
								state_q <= ST_FIN;
							end else begin
								cur_q   <= pos_q;
								state_q <= ST_DRD;
							end
						end
						default: begin
							value_q <= 32'(rdata_q);
							if (!is_take) begin
								state_q <= ST_FIN;
							end else if (pos_q == '0) begin
								// taking rank 0 only moves the head
								first_q <= slot;
								count_q <= count_q - CW'(1);
								state_q <= ST_FIN;
							end else begin
								cur_q   <= pos_q;
								state_q <= ST_DRD;
							end
						end
					endcase
				end
				ST_ISH_RD: begin
					if (cur_q > pos_q) begin
						state_q <= ST_ISH_WR;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= ST_FIN;
					end
				end
				ST_ISH_WR: begin
					cur_q   <= cur_q - CW'(1);
					state_q <= ST_ISH_RD;
				end
				ST_DRD: begin
					if ((cur_q + CW'(1)) < count_q) begin
						state_q <= ST_DWR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= ST_FIN;
					end
				end
				ST_DWR: begin
					cur_q   <= cur_q + CW'(1);
					state_q <= ST_DRD;
				end
				ST_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.status <= status_q;
						rsp_q.value  <= value_q;
						rsp_q.count  <= 7'(count_q);
						rsp_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("key count above capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(SW + 1)'(first_q) < (SW + 1)'(CAPACITY))
		else $error("head slot out of range");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCMP) |-> (lo_q < hi_q && hi_q <= count_q))
		else $error("binary search window broken");

	a_fail_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && status_q != sks_pkg::STAT_OK) |-> (value_q == '0))
		else $error("value set on a failed request");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_START && $past(state_q) != ST_START) |->
		(count_q == $past(count_q) || count_q == $past(count_q) + CW'(1)
		|| count_q == $past(count_q) - CW'(1)))
		else $error("key count jumped by more than one");

endmodule

`default_nettype wire

// File: bench/sorted_key_set_table_tb.sv
`timescale 1ns / 1ps

module sorted_key_set_table_tb;

	localparam int SET_DEPTH    = 64;
	localparam int RANDOM_ITEMS = 1200;
	localparam int CYCLE_LIMIT  = 1000000;
	// longest request: shift every key plus the search
	localparam int DRAIN_CYCLES = 160;

	// request codes the block leaves alone
	localparam logic [3:0] OP_SPARE_FIRST = 4'd13;
	localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	sks_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	sks_pkg::rsp_t rsp;

	// shadow of the table contents, rank order
	logic [31:0]   held_keys [SET_DEPTH];
	int            held_count = 0;
	sks_pkg::rsp_t expected_rsp [$];

	bit no_idle      = 1'b0;
	int errors       = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int peak_count   = 0;
	int full_rejects = 0;
	int cycle_count  = 0;

	sorted_key_set_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// first rank whose key is >= k, or > k when strict
	function automatic int rank_at_or_above(logic [31:0] k, bit strict);
		int pos;
		pos = 0;
		while (pos < held_count && (held_keys[pos] < k || (strict && held_keys[pos] == k)))
			pos++;
		return pos;
	endfunction

	function automatic bit key_held(logic [31:0] k);
		int pos;
		pos = rank_at_or_above(k, 1'b0);
		return pos < held_count && held_keys[pos] == k;
	endfunction

	function automatic void drop_held(int pos);
		for (int i = pos; i < held_count - 1; i++)
			held_keys[i] = held_keys[i + 1];
		held_count--;
	endfunction

	function automatic sks_pkg::rsp_t predict_table_rsp(sks_pkg::req_t r);
		sks_pkg::rsp_t res;
		int            pos;
		res = '0;
		res.status = sks_pkg::STAT_OK;
		case (r.req_type)
			sks_pkg::OP_INSERT: begin
				pos = rank_at_or_above(r.key, 1'b0);
				if (key_held(r.key)) begin
					res.status = sks_pkg::STAT_MISS;
				end else if (held_count >= SET_DEPTH) begin
					res.status = sks_pkg::STAT_FULL;
					full_rejects++;
				end else begin
					for (int i = held_count; i > pos; i--)
						held_keys[i] = held_keys[i - 1];
					held_keys[pos] = r.key;
					held_count++;
				end
			end
			sks_pkg::OP_REMOVE, sks_pkg::OP_EXISTS: begin
				pos = rank_at_or_above(r.key, 1'b0);
				if (!key_held(r.key))
					res.status = sks_pkg::STAT_MISS;
				else if (r.req_type == sks_pkg::OP_REMOVE)
					drop_held(pos);
			end
			sks_pkg::OP_MIN, sks_pkg::OP_MAX, sks_pkg::OP_TAKE_MIN, sks_pkg::OP_TAKE_MAX: begin
				if (held_count == 0) begin
					res.status = sks_pkg::STAT_EMPTY;
				end else begin
					pos = (r.req_type == sks_pkg::OP_MIN || r.req_type == sks_pkg::OP_TAKE_MIN)
						? 0 : held_count - 1;
					res.value = held_keys[pos];
					if (r.req_type == sks_pkg::OP_TAKE_MIN
						|| r.req_type == sks_pkg::OP_TAKE_MAX)
						drop_held(pos);
				end
			end
			sks_pkg::OP_PRED, sks_pkg::OP_TAKE_PRED: begin
				pos = rank_at_or_above(r.key, 1'b0) - 1;
				if (held_count == 0) begin
					res.status = sks_pkg::STAT_EMPTY;
				end else if (pos < 0) begin
					res.status = sks_pkg::STAT_NONE;
				end else begin
					res.value = held_keys[pos];
					if (r.req_type == sks_pkg::OP_TAKE_PRED)
						drop_held(pos);
				end
			end
			sks_pkg::OP_SUCC, sks_pkg::OP_TAKE_SUCC: begin
				pos = rank_at_or_above(r.key, 1'b1);
				if (held_count == 0) begin
					res.status = sks_pkg::STAT_EMPTY;
				end else if (pos >= held_count) begin
					res.status = sks_pkg::STAT_NONE;
				end else begin
					res.value = held_keys[pos];
					if (r.req_type == sks_pkg::OP_TAKE_SUCC)
						drop_held(pos);
				end
			end
			sks_pkg::OP_RANK: begin
				if (int'(r.rank_index) >= held_count)
					res.status = sks_pkg::STAT_RANGE;
				else
					res.value = held_keys[r.rank_index];
			end
			sks_pkg::OP_CLEAR: held_count = 0;
			default: ;
		endcase
		res.count = 7'(held_count);
		if (held_count > peak_count)
			peak_count = held_count;
		return res;
	endfunction

	// keys at or next to ones already held, edge keys and random keys, so searches hit and miss
	function automatic logic [31:0] pick_key(int hit_pct);
		int          sel;
		logic [31:0] near;
		sel = $urandom_range(99);
		if (held_count != 0)
			near = held_keys[$urandom_range(held_count - 1)];
		else
			near = $urandom();
		if (sel < hit_pct)
			return near;
		if (sel < hit_pct + 20)
			return $urandom_range(1) ? near + 32'd1 : near - 32'd1;
		if (sel < hit_pct + 30) begin
			case ($urandom_range(3))
				0: return 32'h0000_0000;
				1: return 32'h0000_0001;
				2: return 32'hFFFF_FFFE;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [5:0] pick_rank();
		if (held_count != 0 && $urandom_range(1) == 1)
			return 6'($urandom_range(held_count - 1));
		return 6'($urandom_range(63));
	endfunction

	task automatic send_req(input logic [3:0] op, input logic [31:0] k, input logic [5:0] idx);
		sks_pkg::req_t r;
		r.req_type   = op;
		r.key        = k;
		r.rank_index = idx;
		if (!no_idle) begin
			while ($urandom_range(99) < 13) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		expected_rsp.push_back(predict_table_rsp(r));
		items_sent++;
	endtask

	// hold off new items until every result is back
	task automatic wait_for_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_rsp.size() != 0);
	endtask

	task automatic test_empty_table();
		send_req(sks_pkg::OP_MIN, $urandom(), 6'd0);
		send_req(sks_pkg::OP_MAX, $urandom(), 6'd0);
		send_req(sks_pkg::OP_TAKE_MIN, $urandom(), 6'd0);
		send_req(sks_pkg::OP_TAKE_MAX, $urandom(), 6'd0);
		send_req(sks_pkg::OP_PRED, $urandom(), 6'd0);
		send_req(sks_pkg::OP_TAKE_PRED, $urandom(), 6'd0);
		send_req(sks_pkg::OP_SUCC, $urandom(), 6'd0);
		send_req(sks_pkg::OP_TAKE_SUCC, $urandom(), 6'd0);
		send_req(sks_pkg::OP_RANK, $urandom(), 6'd0);
		send_req(sks_pkg::OP_REMOVE, $urandom(), 6'd0);
		send_req(sks_pkg::OP_EXISTS, $urandom(), 6'd0);
	endtask

	task automatic test_edge_keys();
		send_req(sks_pkg::OP_INSERT, 32'h0000_0000, 6'd0);
		send_req(sks_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63);
		send_req(sks_pkg::OP_INSERT, 32'h0000_0000, 6'd0);
		send_req(sks_pkg::OP_EXISTS, 32'hFFFF_FFFF, 6'd0);
		send_req(sks_pkg::OP_PRED, 32'h0000_0000, 6'd0);
		send_req(sks_pkg::OP_SUCC, 32'hFFFF_FFFF, 6'd0);
		send_req(sks_pkg::OP_PRED, 32'hFFFF_FFFF, 6'd0);
		send_req(sks_pkg::OP_SUCC, 32'h0000_0000, 6'd0);
		send_req(sks_pkg::OP_RANK, 32'h0000_0000, 6'd1);
		send_req(sks_pkg::OP_RANK, 32'hFFFF_FFFF, 6'd63);
		send_req(sks_pkg::OP_REMOVE, 32'h5A5A_5A5A, 6'd0);
		send_req(OP_SPARE_FIRST, 32'h0000_0000, 6'd0);
		send_req(OP_SPARE_LAST, 32'hFFFF_FFFF, 6'd63);
		send_req(sks_pkg::OP_TAKE_SUCC, 32'h0000_0000, 6'd0);
		send_req(sks_pkg::OP_TAKE_PRED, 32'h0000_0001, 6'd0);
		send_req(sks_pkg::OP_INSERT, 32'h8000_0001, 6'd0);
		send_req(sks_pkg::OP_CLEAR, 32'h0000_0000, 6'd0);
	endtask

	task automatic test_full_table();
		logic [31:0] fresh;
		send_req(sks_pkg::OP_CLEAR, $urandom(), 6'd0);
		while (held_count < SET_DEPTH)
			send_req(sks_pkg::OP_INSERT, $urandom(), pick_rank());
		send_req(sks_pkg::OP_RANK, $urandom(), 6'd63);
		do fresh = $urandom(); while (key_held(fresh));
		send_req(sks_pkg::OP_INSERT, fresh, 6'd0);
		// a duplicate on a full table reports the duplicate, not full
		send_req(sks_pkg::OP_INSERT, held_keys[$urandom_range(SET_DEPTH - 1)], 6'd0);
		send_req(sks_pkg::OP_TAKE_MAX, $urandom(), 6'd0);
		send_req(sks_pkg::OP_INSERT, fresh, 6'd0);
		send_req(sks_pkg::OP_TAKE_MIN, $urandom(), 6'd0);
		send_req(sks_pkg::OP_REMOVE, held_keys[20], 6'd0);
		send_req(sks_pkg::OP_PRED, held_keys[30], 6'd0);
		send_req(sks_pkg::OP_TAKE_SUCC, held_keys[30], 6'd0);
		send_req(sks_pkg::OP_RANK, $urandom(), 6'd62);
	endtask

	// alternating grow and shrink rounds so the table swings between empty and full
	task automatic test_random_mix();
		int         done;
		int         pick;
		bit         grow;
		logic [3:0] op;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			grow    = ((done / 200) % 2) == 0;
			no_idle = (done >= 500 && done < 700);
			pick    = $urandom_range(99);
			if (pick < (grow ? 60 : 25))
				op = sks_pkg::OP_INSERT;
			else if (pick < 99)
				op = 4'($urandom_range(sks_pkg::OP_REMOVE, sks_pkg::OP_RANK));
			else
				op = 4'($urandom_range(grow ? OP_SPARE_FIRST : sks_pkg::OP_CLEAR,
					OP_SPARE_LAST));
			send_req(op, pick_key(op == sks_pkg::OP_INSERT ? 10 : 45), pick_rank());
			if (op <= sks_pkg::OP_CLEAR)
				done++;
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk)
		rsp_ready <= no_idle || ($urandom_range(99) >= 13);

	always @(posedge clk) begin : check_results
		sks_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_seen++;
			if (expected_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: status %0d value %h count %0d",
					$time, rsp.status, rsp.value, rsp.count);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp !== want) begin
					errors++;
					$display("%0t: expected status %0d value %h count %0d, got status %0d value %h count %0d",
						$time, want.status, want.value, want.count,
						rsp.status, rsp.value, rsp.count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, expected_rsp.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_edge_keys();
		wait_for_results();
		test_full_table();
		wait_for_results();
		test_random_mix();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests over all ops and edge keys, checked %0d results, %0d bad.",
			items_sent, results_seen, errors);
		$display("Table peaked at %0d keys; %0d inserts bounced off a full table.",
			peak_count, full_rejects);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/sks_pkg.sv
hw/rtl/sorted_key_set_table.sv
bench/sorted_key_set_table_tb.sv
